// ===== design/scp_pkg.sv =====
// Shared types and constants for the segment closest-points block.
// No dependencies; every other file imports this package.
package scp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int FIELD_W        = 16;
	localparam int POINT_W        = 32;
	localparam int PARAM_W        = 24;
	localparam int MODE_W         = 4;

	// quotient magnitude bits kept before rounding, saturation cap is 2**QBITS
	localparam int QBITS   = 26;
	localparam int DIV_LAT = QBITS + 3;
	localparam int MUL_LAT = 2;

	localparam logic [MODE_W-1:0] CLAMP_RESET = 4'hF;
	localparam int CLAMP_S_LO = 0;
	localparam int CLAMP_S_HI = 1;
	localparam int CLAMP_T_LO = 2;
	localparam int CLAMP_T_HI = 3;

	typedef struct packed {
		logic signed [FIELD_W-1:0] p_start_x;
		logic signed [FIELD_W-1:0] p_start_y;
		logic signed [FIELD_W-1:0] p_start_z;
		logic signed [FIELD_W-1:0] p_end_x;
		logic signed [FIELD_W-1:0] p_end_y;
		logic signed [FIELD_W-1:0] p_end_z;
		logic signed [FIELD_W-1:0] q_start_x;
		logic signed [FIELD_W-1:0] q_start_y;
		logic signed [FIELD_W-1:0] q_start_z;
		logic signed [FIELD_W-1:0] q_end_x;
		logic signed [FIELD_W-1:0] q_end_y;
		logic signed [FIELD_W-1:0] q_end_z;
	} item_t;

	typedef struct packed {
		logic signed [POINT_W-1:0] near_p_x;
		logic signed [POINT_W-1:0] near_p_y;
		logic signed [POINT_W-1:0] near_p_z;
		logic signed [POINT_W-1:0] near_q_x;
		logic signed [POINT_W-1:0] near_q_y;
		logic signed [POINT_W-1:0] near_q_z;
		logic signed [PARAM_W-1:0] param_s;
		logic signed [PARAM_W-1:0] param_t;
	} result_t;

endpackage

// ===== design/scp_wmul.sv =====
// Two-stage signed multiplier built from four half-width partial products.
// Depends on scp_pkg.
module scp_wmul import scp_pkg::*; #(
	parameter int W = 36
) (
	input  logic                  clk,
	input  logic signed [W-1:0]   x,
	input  logic signed [W-1:0]   y,
	output logic signed [2*W-1:0] p
);
	localparam int H  = W / 2;
	localparam int HW = W - H;
	localparam int PW = 2 * W;

	logic signed [2*HW-1:0]   hh_s1;
	logic signed [HW+H:0]     hl_s1, lh_s1;
	logic        [2*H-1:0]    ll_s1;

	always_ff @(posedge clk) begin
		hh_s1 <= $signed(x[W-1:H]) * $signed(y[W-1:H]);
		hl_s1 <= $signed(x[W-1:H]) * $signed({1'b0, y[H-1:0]});
		lh_s1 <= $signed(y[W-1:H]) * $signed({1'b0, x[H-1:0]});
		ll_s1 <= x[H-1:0] * y[H-1:0];
	end

	always_ff @(posedge clk) begin
		p <= (PW'(hh_s1) <<< (2 * H)) + ((PW'(hl_s1) + PW'(lh_s1)) <<< H)
			+ $signed(PW'(ll_s1));
	end

endmodule

// ===== design/scp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, rounded and saturated.
// Depends on scp_pkg.
module scp_div import scp_pkg::*; #(
	parameter int NW        = 73,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic signed [NW-1:0]      num,
	input  logic signed [NW-1:0]      den,
	output logic signed [PARAM_W-1:0] quo
);
	localparam int RW = NW + FRAC_BITS + QBITS + 1;
	localparam logic [QBITS:0] CAP = (QBITS + 1)'(1) << QBITS;
	localparam logic [QBITS:0] LIM = (QBITS + 1)'(1) << (PARAM_W - 1);

	logic [NW-1:0] mn_s0, md_s0;
	logic          neg_s0, zero_s0;

	logic [RW-1:0]    rem_s  [QBITS+1];
	logic [QBITS-1:0] q_s    [QBITS+1];
	logic [NW-1:0]    md_s   [QBITS+1];
	logic             neg_s  [QBITS+1];
	logic             zero_s [QBITS+1];
	logic             over_s [QBITS+1];

	logic [QBITS:0]         mag, mag_sat;
	logic [PARAM_W-1:0]     quo_d;

	always_ff @(posedge clk) begin
		neg_s0  <= num[NW-1] ^ den[NW-1];
		zero_s0 <= (num == '0) || (den == '0);
		mn_s0   <= num[NW-1] ? NW'(-num) : NW'(num);
		md_s0   <= den[NW-1] ? NW'(-den) : NW'(den);
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= RW'(mn_s0) << (FRAC_BITS + 1);
		over_s[0] <= (RW'(mn_s0) << (FRAC_BITS + 1)) >= (RW'(md_s0) << QBITS);
		q_s[0]    <= '0;
		md_s[0]   <= md_s0;
		neg_s[0]  <= neg_s0;
		zero_s[0] <= zero_s0;
	end

	for (genvar k = 0; k < QBITS; k++) begin : g_step
		localparam int B = QBITS - 1 - k;
		logic [RW-1:0] dsh;
		logic          ge;
		assign dsh = RW'(md_s[k]) << B;
		assign ge  = rem_s[k] >= dsh;
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? rem_s[k] - dsh : rem_s[k];
			q_s[k+1]    <= q_s[k] | (ge ? (QBITS'(1) << B) : '0);
			md_s[k+1]   <= md_s[k];
			neg_s[k+1]  <= neg_s[k];
			zero_s[k+1] <= zero_s[k];
			over_s[k+1] <= over_s[k];
		end
	end

	always_comb begin
		mag = over_s[QBITS] ? CAP : ((QBITS + 1)'(q_s[QBITS]) + 1'b1) >> 1;
		if (neg_s[QBITS]) begin
			mag_sat = (mag > LIM) ? LIM : mag;
			quo_d   = PARAM_W'(-mag_sat);
		end else begin
			mag_sat = (mag > LIM - 1'b1) ? LIM - 1'b1 : mag;
			quo_d   = PARAM_W'(mag_sat);
		end
		if (zero_s[QBITS]) begin
			quo_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		quo <= quo_d;
	end

endmodule

// ===== design/segment_closest_points_top.sv =====
// Closest points between two 3-D segments, rays or lines; fully pipelined.
// From start to done: 8 geometry stages, 29 divider stages, 2 point stages.
// Throughput one item per cycle; busy is always low since nothing in the pipe can stall.
// The two quotients run in parallel dividers, each retiring one quotient bit per stage.
// Asynchronous active-low reset clears valid bits and sets clamp_mode to 15.
module segment_closest_points_top import scp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_data,
	output logic              done,
	output result_t           result
);
	localparam int CW  = COORD_BITS;
	localparam int UW  = CW + 1;
	localparam int PW  = 2 * UW;
	localparam int SW  = PW + 2;
	localparam int EW  = SW + 1;
	localparam int NW  = 2 * SW + 1;
	localparam int PRW = PARAM_W + UW;
	localparam int VW  = ((PRW + 1 > CW + 8) ? PRW + 1 : CW + 8) + 1;
	localparam int SH  = FRAC_BITS - 8;
	localparam int RND = (SH > 0) ? (1 << (SH - 1)) : 0;
	localparam int LATENCY = 8 + DIV_LAT + 2;
	localparam logic signed [VW-1:0] VMAX = {{(VW-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {{(VW-31){1'b1}}, {31{1'b0}}};

	typedef struct packed {
		logic [2:0][CW-1:0] p0;
		logic [2:0][CW-1:0] q0;
		logic [2:0][UW-1:0] u;
		logic [2:0][UW-1:0] v;
	} geo_t;

	logic [MODE_W-1:0] clamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= CLAMP_RESET;
		end else if (cfg_we) begin
			clamp_q <= cfg_data;
		end
	end

	assign busy = 1'b0;

	// stage 1: sign-extend coordinates, form direction and offset vectors
	logic signed [CW-1:0] p0_c [3], p1_c [3], q0_c [3], q1_c [3];
	assign p0_c[0] = CW'(item.p_start_x);
	assign p0_c[1] = CW'(item.p_start_y);
	assign p0_c[2] = CW'(item.p_start_z);
	assign p1_c[0] = CW'(item.p_end_x);
	assign p1_c[1] = CW'(item.p_end_y);
	assign p1_c[2] = CW'(item.p_end_z);
	assign q0_c[0] = CW'(item.q_start_x);
	assign q0_c[1] = CW'(item.q_start_y);
	assign q0_c[2] = CW'(item.q_start_z);
	assign q1_c[0] = CW'(item.q_end_x);
	assign q1_c[1] = CW'(item.q_end_y);
	assign q1_c[2] = CW'(item.q_end_z);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	geo_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;
	logic signed [UW-1:0] w_s1 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			geo_s1.p0[i] <= p0_c[i];
			geo_s1.q0[i] <= q0_c[i];
			geo_s1.u[i]  <= UW'(p1_c[i]) - UW'(p0_c[i]);
			geo_s1.v[i]  <= UW'(q1_c[i]) - UW'(q0_c[i]);
			w_s1[i]      <= UW'(p0_c[i]) - UW'(q0_c[i]);
		end
	end

	// stage 2: component products
	logic signed [PW-1:0] uu_s2 [3], uv_s2 [3], vv_s2 [3], uw_s2 [3], vw_s2 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			uu_s2[i] <= $signed(geo_s1.u[i]) * $signed(geo_s1.u[i]);
			uv_s2[i] <= $signed(geo_s1.u[i]) * $signed(geo_s1.v[i]);
			vv_s2[i] <= $signed(geo_s1.v[i]) * $signed(geo_s1.v[i]);
			uw_s2[i] <= $signed(geo_s1.u[i]) * w_s1[i];
			vw_s2[i] <= $signed(geo_s1.v[i]) * w_s1[i];
		end
		geo_s2 <= geo_s1;
	end

	// stage 3: dot products
	logic signed [SW-1:0] a_s3, b_s3, c_s3, d_s3, e_s3;

	always_ff @(posedge clk) begin
		a_s3   <= SW'(uu_s2[0]) + SW'(uu_s2[1]) + SW'(uu_s2[2]);
		b_s3   <= SW'(uv_s2[0]) + SW'(uv_s2[1]) + SW'(uv_s2[2]);
		c_s3   <= SW'(vv_s2[0]) + SW'(vv_s2[1]) + SW'(vv_s2[2]);
		d_s3   <= SW'(uw_s2[0]) + SW'(uw_s2[1]) + SW'(uw_s2[2]);
		e_s3   <= SW'(vw_s2[0]) + SW'(vw_s2[1]) + SW'(vw_s2[2]);
		geo_s3 <= geo_s2;
	end

	// stages 4 and 5: wide products in split multipliers
	logic signed [2*SW-1:0] ac_s5, bb_s5, be_s5, cd_s5, ae_s5, bd_s5;

	scp_wmul #(.W(SW)) u_mul_ac (.clk(clk), .x(a_s3), .y(c_s3), .p(ac_s5));
	scp_wmul #(.W(SW)) u_mul_bb (.clk(clk), .x(b_s3), .y(b_s3), .p(bb_s5));
	scp_wmul #(.W(SW)) u_mul_be (.clk(clk), .x(b_s3), .y(e_s3), .p(be_s5));
	scp_wmul #(.W(SW)) u_mul_cd (.clk(clk), .x(c_s3), .y(d_s3), .p(cd_s5));
	scp_wmul #(.W(SW)) u_mul_ae (.clk(clk), .x(a_s3), .y(e_s3), .p(ae_s5));
	scp_wmul #(.W(SW)) u_mul_bd (.clk(clk), .x(b_s3), .y(d_s3), .p(bd_s5));

	logic signed [SW-1:0] a_s4, b_s4, c_s4, d_s4, e_s4;
	logic signed [SW-1:0] a_s5, b_s5, c_s5, d_s5, e_s5;

	always_ff @(posedge clk) begin
		a_s4 <= a_s3; b_s4 <= b_s3; c_s4 <= c_s3; d_s4 <= d_s3; e_s4 <= e_s3;
		a_s5 <= a_s4; b_s5 <= b_s4; c_s5 <= c_s4; d_s5 <= d_s4; e_s5 <= e_s4;
		geo_s4 <= geo_s3;
		geo_s5 <= geo_s4;
	end

	// stage 6: determinant and numerators
	logic signed [NW-1:0] dd_s6, sn_s6, tn_s6;
	logic signed [SW-1:0] a_s6, c_s6, e_s6;
	logic signed [EW-1:0] ebs_s6, bmd_s6, nd_s6;

	always_ff @(posedge clk) begin
		dd_s6  <= NW'(ac_s5) - NW'(bb_s5);
		sn_s6  <= NW'(be_s5) - NW'(cd_s5);
		tn_s6  <= NW'(ae_s5) - NW'(bd_s5);
		ebs_s6 <= EW'(e_s5) + EW'(b_s5);
		bmd_s6 <= EW'(b_s5) - EW'(d_s5);
		nd_s6  <= -EW'(d_s5);
		a_s6   <= a_s5;
		c_s6   <= c_s5;
		e_s6   <= e_s5;
		geo_s6 <= geo_s5;
	end

	// stage 7: parallel case and clamps on s
	logic signed [NW-1:0] sn_d7, sd_d7, tn_d7, td_d7;
	logic signed [NW-1:0] sn_s7, sd_s7, tn_s7, td_s7;
	logic signed [EW-1:0] nd_s7, bmd_s7;
	logic signed [SW-1:0] a_s7;
	logic                 nd_neg_s7, nd_gt_a_s7, bmd_neg_s7, bmd_gt_a_s7;

	always_comb begin
		sn_d7 = sn_s6;
		sd_d7 = dd_s6;
		tn_d7 = tn_s6;
		td_d7 = dd_s6;
		priority if (dd_s6 == '0) begin
			sn_d7 = '0;
			sd_d7 = NW'(1);
			tn_d7 = NW'(e_s6);
			td_d7 = NW'(c_s6);
		end else if (clamp_q[CLAMP_S_LO] && sn_s6 < 0) begin
			sn_d7 = '0;
			tn_d7 = NW'(e_s6);
			td_d7 = NW'(c_s6);
		end else if (clamp_q[CLAMP_S_HI] && dd_s6 < sn_s6) begin
			sn_d7 = dd_s6;
			tn_d7 = NW'(ebs_s6);
			td_d7 = NW'(c_s6);
		end else begin
			sn_d7 = sn_s6;
		end
	end

	always_ff @(posedge clk) begin
		sn_s7       <= sn_d7;
		sd_s7       <= sd_d7;
		tn_s7       <= tn_d7;
		td_s7       <= td_d7;
		nd_s7       <= nd_s6;
		bmd_s7      <= bmd_s6;
		a_s7        <= a_s6;
		nd_neg_s7   <= nd_s6 < 0;
		nd_gt_a_s7  <= nd_s6 > EW'(a_s6);
		bmd_neg_s7  <= bmd_s6 < 0;
		bmd_gt_a_s7 <= bmd_s6 > EW'(a_s6);
		geo_s7      <= geo_s6;
	end

	// stage 8: clamps on t, recompute s for a clamped t
	logic signed [NW-1:0] sn_d8, sd_d8, tn_d8;
	logic signed [NW-1:0] sn_s8, sd_s8, tn_s8, td_s8;

	always_comb begin
		sn_d8 = sn_s7;
		sd_d8 = sd_s7;
		tn_d8 = tn_s7;
		priority if (clamp_q[CLAMP_T_LO] && tn_s7 < 0) begin
			tn_d8 = '0;
			priority if (clamp_q[CLAMP_S_LO] && nd_neg_s7) begin
				sn_d8 = '0;
			end else if (clamp_q[CLAMP_S_HI] && nd_gt_a_s7) begin
				sn_d8 = sd_s7;
			end else begin
				sn_d8 = NW'(nd_s7);
				sd_d8 = NW'(a_s7);
			end
		end else if (clamp_q[CLAMP_T_HI] && td_s7 < tn_s7) begin
			tn_d8 = td_s7;
			priority if (clamp_q[CLAMP_S_LO] && bmd_neg_s7) begin
				sn_d8 = '0;
			end else if (clamp_q[CLAMP_S_HI] && bmd_gt_a_s7) begin
				sn_d8 = sd_s7;
			end else begin
				sn_d8 = NW'(bmd_s7);
				sd_d8 = NW'(a_s7);
			end
		end else begin
			tn_d8 = tn_s7;
		end
	end

	always_ff @(posedge clk) begin
		sn_s8  <= sn_d8;
		sd_s8  <= sd_d8;
		tn_s8  <= tn_d8;
		td_s8  <= td_s7;
		geo_s8 <= geo_s7;
	end

	// divider stages
	logic signed [PARAM_W-1:0] s_par, t_par;

	scp_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_s (
		.clk(clk), .num(sn_s8), .den(sd_s8), .quo(s_par)
	);
	scp_div #(.NW(NW), .FRAC_BITS(FRAC_BITS)) u_div_t (
		.clk(clk), .num(tn_s8), .den(td_s8), .quo(t_par)
	);

	geo_t geo_dly [DIV_LAT];
	logic [DIV_LAT-1:0] valid_dly;

	always_ff @(posedge clk) begin
		geo_dly[0] <= geo_s8;
		for (int i = 1; i < DIV_LAT; i++) begin
			geo_dly[i] <= geo_dly[i-1];
		end
	end

	// valid bits for every stage
	logic valid_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_dly <= '0;
			valid_p1  <= 1'b0;
			done      <= 1'b0;
		end else begin
			valid_s1  <= start && !busy;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= valid_s6;
			valid_s8  <= valid_s7;
			valid_dly <= {valid_dly[DIV_LAT-2:0], valid_s8};
			valid_p1  <= valid_dly[DIV_LAT-1];
			done      <= valid_p1;
		end
	end

	// point stage 1: parameter times direction
	logic signed [PRW-1:0]     prod_p_p1 [3], prod_q_p1 [3];
	logic signed [CW-1:0]      base_p_p1 [3], base_q_p1 [3];
	logic signed [PARAM_W-1:0] s_p1, t_p1;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_p_p1[i] <= s_par * $signed(geo_dly[DIV_LAT-1].u[i]);
			prod_q_p1[i] <= t_par * $signed(geo_dly[DIV_LAT-1].v[i]);
			base_p_p1[i] <= $signed(geo_dly[DIV_LAT-1].p0[i]);
			base_q_p1[i] <= $signed(geo_dly[DIV_LAT-1].q0[i]);
		end
		s_p1 <= s_par;
		t_p1 <= t_par;
	end

	// round the offset to 8 fraction bits, add the start point, saturate
	function automatic logic signed [POINT_W-1:0] point_f(
		input logic signed [CW-1:0]  base,
		input logic signed [PRW-1:0] prod
	);
		logic [PRW:0]           mag;
		logic signed [VW-1:0]   off, val;
		mag = prod[PRW-1] ? (PRW + 1)'(-prod) : (PRW + 1)'(prod);
		mag = (mag + (PRW + 1)'(RND)) >> SH;
		off = prod[PRW-1] ? -VW'($signed({1'b0, mag})) : VW'($signed({1'b0, mag}));
		val = (VW'(base) <<< 8) + off;
		if (val > VMAX) begin
			val = VMAX;
		end else if (val < VMIN) begin
			val = VMIN;
		end
		return POINT_W'(val);
	endfunction

	always_ff @(posedge clk) begin
		result.near_p_x <= point_f(base_p_p1[0], prod_p_p1[0]);
		result.near_p_y <= point_f(base_p_p1[1], prod_p_p1[1]);
		result.near_p_z <= point_f(base_p_p1[2], prod_p_p1[2]);
		result.near_q_x <= point_f(base_q_p1[0], prod_q_p1[0]);
		result.near_q_y <= point_f(base_q_p1[1], prod_q_p1[1]);
		result.near_q_z <= point_f(base_q_p1[2], prod_q_p1[2]);
		result.param_s  <= s_p1;
		result.param_t  <= t_p1;
	end

endmodule

// ===== design/scp_check.sv =====
// Port-level checks for segment_closest_points_top, bound to every instance.
// Depends on scp_pkg and the top level's ports.
module scp_check import scp_pkg::*; #(
	parameter int LAT = 39
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input item_t   item,
	input logic    done,
	input result_t result
);

	// every result beat stems from an item taken a fixed latency earlier
	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without a matching item");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

	// a zero parameter leaves the start point, scaled to Q24.8
	a_s_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.param_s == '0) |->
		result.near_p_x == {{8{$past(item.p_start_x[FIELD_W-1], LAT)}},
			$past(item.p_start_x, LAT), 8'h00})
		else $error("near_p_x off the start point for zero s");

	a_t_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.param_t == '0) |->
		result.near_q_z == {{8{$past(item.q_start_z[FIELD_W-1], LAT)}},
			$past(item.q_start_z, LAT), 8'h00})
		else $error("near_q_z off the start point for zero t");

endmodule

bind segment_closest_points_top scp_check #(.LAT(LATENCY)) u_scp_check (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.item(item),
	.done(done),
	.result(result)
);

// ===== test/segment_closest_points_checker.sv =====
// Checker for segment_closest_points_top: predicts every beat and compares results.
// Depends on scp_pkg for the item and result types and the clamp bit positions.
`timescale 1ns / 1ps

module segment_closest_points_checker import scp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  item_t             item,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_data,
	input  logic              done,
	input  result_t           result,
	output int                fail_count,
	output int                pending
);

	typedef logic signed [127:0] wide_t;

	logic [MODE_W-1:0] clamp_mode_q;
	result_t           expected_points[$];

	// Quotient n/dn with 16 fraction bits, rounded half away from zero, saturated to 24 bits.
	function automatic longint param_quotient(wide_t n, wide_t dn);
		logic [127:0] mn, md, q, mag;
		bit           neg;
		if (n == 0 || dn == 0)
			return 0;
		neg = (n < 0) != (dn < 0);
		mn  = n < 0 ? -n : n;
		md  = dn < 0 ? -dn : dn;
		q   = (mn << (FRAC_BITS_DEF + 1)) / md;
		mag = q >= (128'd1 << QBITS) ? (128'd1 << QBITS) : (q + 1) >> 1;
		if (neg) begin
			if (mag > (128'd1 << 23))
				mag = 128'd1 << 23;
			return -longint'(mag);
		end
		if (mag > (128'd1 << 23) - 1)
			mag = (128'd1 << 23) - 1;
		return longint'(mag);
	endfunction

	function automatic logic [POINT_W-1:0] near_point(longint base, longint par, longint dir);
		longint prod, m, off, val;
		prod = par * dir;
		m    = prod < 0 ? -prod : prod;
		m    = (m + (64'sd1 << (FRAC_BITS_DEF - 9))) >>> (FRAC_BITS_DEF - 8);
		off  = prod < 0 ? -m : m;
		val  = base * 256 + off;
		if (val > 64'sd2147483647)
			val = 64'sd2147483647;
		if (val < -64'sd2147483648)
			val = -64'sd2147483648;
		return val[POINT_W-1:0];
	endfunction

	function automatic result_t closest_points(item_t it, logic [MODE_W-1:0] mode);
		longint  p0[3], q0[3], u[3], v[3], w[3];
		longint  a, b, c, d, e, s, t;
		wide_t   dd, sn, sd, tn, td;
		result_t r;
		p0[0] = it.p_start_x; p0[1] = it.p_start_y; p0[2] = it.p_start_z;
		q0[0] = it.q_start_x; q0[1] = it.q_start_y; q0[2] = it.q_start_z;
		u[0] = longint'(it.p_end_x) - p0[0];
		u[1] = longint'(it.p_end_y) - p0[1];
		u[2] = longint'(it.p_end_z) - p0[2];
		v[0] = longint'(it.q_end_x) - q0[0];
		v[1] = longint'(it.q_end_y) - q0[1];
		v[2] = longint'(it.q_end_z) - q0[2];
		a = 0; b = 0; c = 0; d = 0; e = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = p0[i] - q0[i];
			a += u[i] * u[i]; b += u[i] * v[i]; c += v[i] * v[i];
			d += u[i] * w[i]; e += v[i] * w[i];
		end
		dd = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
		sd = dd; td = dd;
		if (dd == 0) begin
			// parallel: pin s to the start of P
			sn = 0; sd = 1; tn = e; td = c;
		end else begin
			sn = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
			tn = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(d);
			if (mode[CLAMP_S_LO] && sn < 0) begin
				sn = 0; tn = e; td = c;
			end else if (mode[CLAMP_S_HI] && sd < sn) begin
				sn = sd; tn = e + b; td = c;
			end
		end
		// clamp t, then recompute s for the clamped end
		if (mode[CLAMP_T_LO] && tn < 0) begin
			tn = 0;
			if (mode[CLAMP_S_LO] && -d < 0)
				sn = 0;
			else if (mode[CLAMP_S_HI] && -d > a)
				sn = sd;
			else begin
				sn = -d; sd = a;
			end
		end else if (mode[CLAMP_T_HI] && td < tn) begin
			tn = td;
			if (mode[CLAMP_S_LO] && b - d < 0)
				sn = 0;
			else if (mode[CLAMP_S_HI] && b - d > a)
				sn = sd;
			else begin
				sn = b - d; sd = a;
			end
		end
		s = param_quotient(sn, sd);
		t = param_quotient(tn, td);
		r.near_p_x = near_point(p0[0], s, u[0]);
		r.near_p_y = near_point(p0[1], s, u[1]);
		r.near_p_z = near_point(p0[2], s, u[2]);
		r.near_q_x = near_point(q0[0], t, v[0]);
		r.near_q_y = near_point(q0[1], t, v[1]);
		r.near_q_z = near_point(q0[2], t, v[2]);
		r.param_s  = s[PARAM_W-1:0];
		r.param_t  = t[PARAM_W-1:0];
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(string what, longint got, longint want);
		if (got != want)
			report(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			clamp_mode_q <= CLAMP_RESET;
		end else begin
			if (cfg_we)
				clamp_mode_q <= cfg_data;
			if (start && !busy)
				expected_points.push_back(closest_points(item, clamp_mode_q));
			if (done) begin
				if (expected_points.size() == 0) begin
					report("unexpected result beat", 1, 0);
				end else begin
					want = expected_points.pop_front();
					check_field("near_p_x", result.near_p_x, want.near_p_x);
					check_field("near_p_y", result.near_p_y, want.near_p_y);
					check_field("near_p_z", result.near_p_z, want.near_p_z);
					check_field("near_q_x", result.near_q_x, want.near_q_x);
					check_field("near_q_y", result.near_q_y, want.near_q_y);
					check_field("near_q_z", result.near_q_z, want.near_q_z);
					check_field("param_s", result.param_s, want.param_s);
					check_field("param_t", result.param_t, want.param_t);
				end
			end
		end
		pending = expected_points.size();
	end

	initial begin
		fail_count = 0;
		pending    = 0;
	end

endmodule

// ===== test/testbench.sv =====
// Top of the segment closest-points testbench: clock, reset, stimulus and verdict.
// Depends on scp_pkg, segment_closest_points_top and segment_closest_points_checker.
`timescale 1ns / 1ps

module testbench import scp_pkg::*;;

	localparam int IDLE_LIMIT = 3000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_data;
	logic              done;
	result_t           result;
	int                fail_count;
	int                pending;
	int                idle_cycles;
	logic              busy_seen;
	bit                use_gaps;

	segment_closest_points_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result)
	);

	segment_closest_points_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// busy only moves after a rising edge, so its value at the falling edge holds for the next one
	always @(negedge clk)
		busy_seen = busy;

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [FIELD_W-1:0] pick(int lim);
		return FIELD_W'($urandom_range(0, 2 * lim) - lim);
	endfunction

	function automatic logic [FIELD_W-1:0] extreme_coord();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	function automatic item_t segment_pair(int kind);
		item_t  it;
		int     lim, k;
		logic [FIELD_W-1:0] f[12];
		lim = kind < 6 ? 200 : 4000;
		for (int i = 0; i < 12; i++) begin
			case (kind)
				0, 1, 2: f[i] = FIELD_W'($urandom());
				8:       f[i] = extreme_coord();
				default: f[i] = pick(lim);
			endcase
		end
		if (kind == 6) begin
			// parallel: Q direction is a multiple of P direction
			k = $urandom_range(0, 6) - 3;
			for (int i = 0; i < 3; i++) begin
				f[3 + i] = pick(300);
				f[i]     = pick(300);
				f[9 + i] = f[6 + i] + FIELD_W'(k * ($signed(f[3 + i]) - $signed(f[i])));
			end
		end else if (kind == 7) begin
			// on each axis, one of the two segments gets zero extent
			for (int i = 0; i < 3; i++) begin
				if ($urandom_range(0, 1))
					f[3 + i] = f[i];
				else
					f[9 + i] = f[6 + i];
			end
		end
		it = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
		return it;
	endfunction

	task automatic send_item(item_t it);
		int gap;
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy_seen);
		gap = 0;
		if (use_gaps) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				5, 6, 7, 8:    gap = $urandom_range(1, 3);
				default:       gap = $urandom_range(5, 40);
			endcase
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		if (start)
			start <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DIV_LAT + 16) @(posedge clk);
	endtask

	task automatic write_mode(logic [MODE_W-1:0] mode);
		cfg_we   <= 1'b1;
		cfg_data <= mode;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	task automatic send_directed();
		send_item('0);
		send_item({{6{16'h8000}}, {6{16'h7FFF}}});
		send_item({{3{16'h8000}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h8000}}});
		send_item({16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000,
			16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h8000});
		// segments crossing in xy projection, offset by 5 in z
		send_item({-16'sd10, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
			16'sd0, -16'sd10, 16'sd5, 16'sd0, 16'sd10, 16'sd5});
		// skew lines whose closest points lie past both ends
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			16'sd50, 16'sd20, 16'sd3, 16'sd50, 16'sd21, 16'sd3});
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			-16'sd50, -16'sd20, 16'sd3, -16'sd50, -16'sd21, 16'sd3});
		// parallel, collinear overlapping and identical
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd4, 16'sd2, 16'sd0,
			16'sd1, 16'sd5, 16'sd0, 16'sd9, 16'sd9, 16'sd0});
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0,
			16'sd5, 16'sd0, 16'sd0, 16'sd20, 16'sd0, 16'sd0});
		send_item({16'sd3, 16'sd4, 16'sd5, 16'sd7, 16'sd8, 16'sd9,
			16'sd3, 16'sd4, 16'sd5, 16'sd7, 16'sd8, 16'sd9});
		// degenerate: one or both segments collapse to a point
		send_item({16'sd3, 16'sd4, 16'sd5, 16'sd3, 16'sd4, 16'sd5,
			16'sd0, 16'sd0, 16'sd0, 16'sd9, 16'sd1, 16'sd2});
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd9, 16'sd1, 16'sd2,
			16'sd3, 16'sd4, 16'sd5, 16'sd3, 16'sd4, 16'sd5});
		send_item({16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1,
			16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7});
		// far tiny segment gives a huge s, saturating s when s is not clamped; t stays zero
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			16'sd32767, 16'sd1, 16'sd0, 16'sd32767, 16'sd1, 16'sd1});
		send_item({16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
			-16'sd32768, 16'sd1, 16'sd0, -16'sd32768, 16'sd1, 16'sd1});
	endtask

	initial begin
		logic [MODE_W-1:0] modes[9];
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		cfg_we      = 1'b0;
		cfg_data    = '0;
		busy_seen   = 1'b0;
		idle_cycles = 0;
		use_gaps    = 1'b0;
		modes = '{4'hF, 4'h0, 4'h5, 4'hA, 4'h3, 4'hC, 4'h1, 4'h8, 4'hF};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			write_mode(ph == 8 ? MODE_W'($urandom()) : modes[ph]);
			if (ph == 1 || ph == 8)
				send_directed();
			use_gaps = (ph % 3) != 2;
			for (int n = 0; n < 80; n++)
				send_item(segment_pair($urandom_range(0, 9)));
		end
		drain();

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
